>>> design/twd_pkg.sv
`timescale 1ns / 1ps
// twd_pkg: shared types and constants for the calibrated water detector
// no dependencies

package twd_pkg;

    localparam int VALUE_W = 16;

    // slot content that marks an empty or invalid calibration sample
    localparam logic [VALUE_W-1:0] INVALID_MARK = 16'hFFFF;
    localparam logic [3:0]         DETECT_SCALE = 4'd10;

    typedef enum logic [1:0] {
        OP_DETECT    = 2'd0,
        OP_REC_AIR   = 2'd1,
        OP_REC_WATER = 2'd2,
        OP_RECOMPUTE = 2'd3
    } op_t;

endpackage

>>> design/twd_cell.sv
`timescale 1ns / 1ps
// twd_cell: one calibration slot of a sample chain
// depends on twd_pkg

module twd_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift_en,
    input  logic [twd_pkg::VALUE_W-1:0] din,
    output logic [twd_pkg::VALUE_W-1:0] dout
);

    logic [twd_pkg::VALUE_W-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= twd_pkg::INVALID_MARK;
        end
        else if (shift_en)
        begin
            value_reg <= din;
        end
    end

    assign dout = value_reg;

endmodule

>>> design/twd_ring.sv
`timescale 1ns / 1ps
// twd_ring: chain of sample cells with running sum and invalid-slot count
// depends on twd_pkg and twd_cell

module twd_ring #(
    parameter int SAMPLES = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    shift_en,
    input  logic [twd_pkg::VALUE_W-1:0]             din,
    output logic [twd_pkg::VALUE_W+$clog2(SAMPLES)-1:0] sum_next,
    output logic                                    full_next
);

    localparam int SUM_W = twd_pkg::VALUE_W + $clog2(SAMPLES);
    localparam int CNT_W = $clog2(SAMPLES + 1);

    logic [twd_pkg::VALUE_W-1:0] cell_q [SAMPLES];
    logic [SUM_W-1:0]            sum_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic                        in_inv;
    logic                        out_inv;

    // newest item enters at the head, the oldest drops off the tail
    for (genvar g = 0; g < SAMPLES; g++)
    begin : g_cell
        twd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .din      ((g == 0) ? din : cell_q[(g == 0) ? 0 : g - 1]),
            .dout     (cell_q[g])
        );
    end

    assign in_inv  = (din == twd_pkg::INVALID_MARK);
    assign out_inv = (cell_q[SAMPLES-1] == twd_pkg::INVALID_MARK);

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (shift_en)
        begin
            // modular update, the true sum never goes negative
            sum_next = sum_reg + SUM_W'(din) - SUM_W'(cell_q[SAMPLES-1]);
            cnt_next = cnt_reg + CNT_W'(in_inv) - CNT_W'(out_inv);
        end
    end

    assign full_next = (cnt_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= SUM_W'(SAMPLES * 65535);
            cnt_reg <= CNT_W'(SAMPLES);
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> design/touch_water_detector_calibrated.sv
`timescale 1ns / 1ps
// touch_water_detector_calibrated: top level, op decode, threshold and output stage
// depends on twd_pkg and twd_ring

// Takes one item per clock cycle on the slave side and returns exactly one
// result item per input item in the cycle after it, through a single output
// register; the input stalls only while that register holds an item the
// master side has not taken. Detect compares reading*10 (mod 65536) with
// the active threshold. Air and water samples shift into two chains of
// SAMPLES cells that keep a running sum and an invalid-slot count, so a
// recompute needs no sweep: it multiplies the registered total of both
// chains by a fixed reciprocal of 2*SAMPLES in the same cycle. No clearing
// pass follows reset. A write on the configuration port loads the active
// threshold directly and should only be issued while no item is in flight.

module touch_water_detector_calibrated #(
    parameter int SAMPLES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,  // start_threshold
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [15:0] reading
    input  logic [1:0]  s_tuser,      // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // [0] water_detected, [16:1] threshold_value, zero pad
    output logic [0:0]  m_tuser       // [0] threshold_changed
);

    localparam int SUM_W = twd_pkg::VALUE_W + $clog2(SAMPLES);
    localparam int TOT_W = SUM_W + 1;
    localparam int DIV   = 2 * SAMPLES;
    localparam int SHIFT = TOT_W + $clog2(DIV);
    localparam int RCP_W = TOT_W + 1;
    localparam int PRD_W = TOT_W + RCP_W;
    // ceil(2^SHIFT / DIV) makes the truncated product exact over TOT_W bits
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(((64'd1 << SHIFT) + DIV - 1) / DIV);

    twd_pkg::op_t op;
    logic         accept;

    logic [SUM_W-1:0] air_sum_next;
    logic [SUM_W-1:0] water_sum_next;
    logic             air_full_next;
    logic             water_full_next;

    logic [TOT_W-1:0] total_reg;
    logic             both_full_reg;
    logic [PRD_W-1:0] product;
    logic [15:0]      new_threshold;

    logic [15:0] threshold_reg;
    logic [15:0] threshold_next;
    logic [19:0] scaled_full;
    logic        detected;
    logic        changed;

    logic        out_valid_reg;
    logic        out_detected_reg;
    logic [15:0] out_threshold_reg;
    logic        out_changed_reg;

    assign op       = twd_pkg::op_t'(s_tuser);
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    twd_ring #(
        .SAMPLES (SAMPLES)
    ) u_air (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (accept && (op == twd_pkg::OP_REC_AIR)),
        .din       (s_tdata),
        .sum_next  (air_sum_next),
        .full_next (air_full_next)
    );

    twd_ring #(
        .SAMPLES (SAMPLES)
    ) u_water (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (accept && (op == twd_pkg::OP_REC_WATER)),
        .din       (s_tdata),
        .sum_next  (water_sum_next),
        .full_next (water_full_next)
    );

    assign product       = PRD_W'(total_reg) * PRD_W'(RECIP);
    assign new_threshold = product[SHIFT +: 16];
    assign scaled_full   = 20'(s_tdata) * 20'(twd_pkg::DETECT_SCALE);

    always_comb
    begin
        detected       = 1'b0;
        changed        = 1'b0;
        threshold_next = threshold_reg;
        if (accept)
        begin
            case (op)
                twd_pkg::OP_DETECT:
                begin
                    detected = (scaled_full[15:0] < threshold_reg);
                end
                twd_pkg::OP_RECOMPUTE:
                begin
                    if (both_full_reg)
                    begin
                        changed        = 1'b1;
                        threshold_next = new_threshold;
                    end
                end
                default:
                begin
                    detected = 1'b0;
                end
            endcase
        end
        if (cfg_wr_en)
        begin
            threshold_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            both_full_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            threshold_reg <= threshold_next;
            both_full_reg <= air_full_next && water_full_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        total_reg <= TOT_W'(air_sum_next) + TOT_W'(water_sum_next);
        if (accept)
        begin
            out_detected_reg  <= detected;
            out_threshold_reg <= threshold_next;
            out_changed_reg   <= changed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_threshold_reg, out_detected_reg};
    assign m_tuser  = out_changed_reg;

`ifndef NO_ASSERTIONS
    // the reported threshold is the one the block goes on using
    a_thr_reported : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (m_tdata[16:1] == threshold_reg))
        else $error("reported threshold differs from active threshold");

    // only a detect can flag water
    a_detect_only : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op != twd_pkg::OP_DETECT)) |=> !m_tdata[0])
        else $error("water flagged on a non-detect item");

    // a change is only reported for a recompute with both chains complete
    a_change_gated : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((op != twd_pkg::OP_RECOMPUTE) || !both_full_reg)) |=> !m_tuser[0])
        else $error("threshold change reported without a complete recompute");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for touch_water_detector_calibrated
// depends on twd_pkg and the design top level, nothing else

module tb;

    localparam int SAMPLES     = 8;
    localparam int HOLD_CYCLES = 60;
    localparam int STUCK_LIMIT = 5000;
    localparam int PHASE_ITEMS = 125;

    typedef struct {
        twd_pkg::op_t op;
        logic [15:0]  reading;
    } touch_cmd_t;

    typedef struct {
        logic        wet;
        logic [15:0] thr;
        logic        reloaded;
    } det_report_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    // own copy of the detector state
    logic [15:0] air_ring [SAMPLES];
    logic [15:0] water_ring [SAMPLES];
    int unsigned air_pos;
    int unsigned water_pos;
    logic [15:0] cur_threshold;

    touch_cmd_t  cmd_queue [$];
    det_report_t due_reports [$];

    int unsigned cmds_queued    = 0;
    int unsigned cmds_taken     = 0;
    int unsigned reports_seen   = 0;
    int unsigned reloads_seen   = 0;
    int unsigned cfg_writes     = 0;
    int unsigned errors         = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_asks      = 0;
    int unsigned hold_served    = 0;
    int unsigned hold_left      = 0;
    int unsigned stuck_cycles   = 0;
    bit          took_item      = 1'b0;

    always #5 clk = ~clk;

    touch_water_detector_calibrated #(
        .SAMPLES(SAMPLES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    function automatic det_report_t detect_step(touch_cmd_t c);
        det_report_t r;
        logic [31:0] air_sum;
        logic [31:0] water_sum;
        logic [15:0] scaled;
        bit          air_ok;
        bit          water_ok;
        r.wet      = 1'b0;
        r.reloaded = 1'b0;
        case (c.op)
            twd_pkg::OP_DETECT:
            begin
                scaled = 16'(32'(c.reading) * 32'(twd_pkg::DETECT_SCALE));
                r.wet  = (scaled < cur_threshold);
            end
            twd_pkg::OP_REC_AIR:
            begin
                air_ring[air_pos] = c.reading;
                air_pos = (air_pos + 1) % SAMPLES;
            end
            twd_pkg::OP_REC_WATER:
            begin
                water_ring[water_pos] = c.reading;
                water_pos = (water_pos + 1) % SAMPLES;
            end
            default:
            begin
                air_sum   = '0;
                water_sum = '0;
                air_ok    = 1'b1;
                water_ok  = 1'b1;
                for (int i = 0; i < SAMPLES; i++)
                begin
                    if (air_ring[i] == twd_pkg::INVALID_MARK)
                        air_ok = 1'b0;
                    if (water_ring[i] == twd_pkg::INVALID_MARK)
                        water_ok = 1'b0;
                    air_sum   = air_sum + air_ring[i];
                    water_sum = water_sum + water_ring[i];
                end
                // reload only with both rings complete
                if (air_ok && water_ok)
                begin
                    cur_threshold = 16'((air_sum + water_sum) / (2 * SAMPLES));
                    r.reloaded    = 1'b1;
                end
            end
        endcase
        r.thr = cur_threshold;
        return r;
    endfunction

    task automatic check_field(string what, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
        end
    endtask

    task automatic push_cmd(twd_pkg::op_t op, logic [15:0] reading);
        touch_cmd_t c;
        c.op      = op;
        c.reading = reading;
        cmd_queue.push_back(c);
        cmds_queued++;
    endtask

    task automatic wait_drained();
        while (cmds_taken != cmds_queued || due_reports.size() != 0)
            @(negedge clk);
        // let the output stage settle
        repeat (3) @(negedge clk);
    endtask

    task automatic write_start_threshold(logic [15:0] value);
        wait_drained();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_writes++;
    endtask

    task automatic queue_random(int n);
        int unsigned  pick;
        twd_pkg::op_t op;
        logic [15:0]  v;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                op = twd_pkg::OP_DETECT;
            else if (pick < 60)
                op = twd_pkg::OP_REC_AIR;
            else if (pick < 80)
                op = twd_pkg::OP_REC_WATER;
            else
                op = twd_pkg::OP_RECOMPUTE;
            v = 16'($urandom);
            if (op == twd_pkg::OP_DETECT && $urandom_range(3) == 0)
                v = 16'(cur_threshold / 10) + 16'($urandom_range(1)); // near the trip point
            else if ((op == twd_pkg::OP_REC_AIR || op == twd_pkg::OP_REC_WATER)
                     && $urandom_range(19) == 0)
                v = twd_pkg::INVALID_MARK;
            push_cmd(op, v);
        end
    endtask

    // input and output sampling, prediction and checking
    always @(posedge clk)
    begin
        touch_cmd_t  c;
        det_report_t want;
        took_item = s_tvalid && s_tready;
        if (cfg_wr_en)
            cur_threshold = cfg_wr_data;
        if (took_item)
        begin
            c.op      = twd_pkg::op_t'(s_tuser);
            c.reading = s_tdata;
            due_reports.push_back(detect_step(c));
            cmds_taken++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            reports_seen++;
            if (m_tuser[0] === 1'b1)
                reloads_seen++;
            if (due_reports.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, expected nothing, got %h/%h",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = due_reports.pop_front();
                check_field("water_detected", 16'(want.wet), 16'(m_tdata[0]));
                check_field("threshold_value", want.thr, m_tdata[16:1]);
                check_field("threshold_changed", 16'(want.reloaded), 16'(m_tuser[0]));
            end
        end
    end

    // sender: holds an offered item until it is taken
    always @(negedge clk)
    begin
        touch_cmd_t c;
        bit         offer;
        offer = s_tvalid && !took_item;
        if (!offer && rst_n && cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            c = cmd_queue.pop_front();
            s_tuser <= c.op;
            s_tdata <= c.reading;
            offer   = 1'b1;
        end
        s_tvalid <= offer;
    end

    // receiver, with a long hold-off when one is asked for
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_asks != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("tb: no item moved for %0d cycles", STUCK_LIMIT);
            $display("tb: done, errors");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        int unsigned idle_tab [4];
        int unsigned stall_tab [4];
        logic [15:0] thr_tab [4];
        for (int i = 0; i < SAMPLES; i++)
        begin
            air_ring[i]   = twd_pkg::INVALID_MARK;
            water_ring[i] = twd_pkg::INVALID_MARK;
        end
        air_pos       = 0;
        water_pos     = 0;
        cur_threshold = '0;
        idle_tab  = '{0, 57, 0, 16};
        stall_tab = '{0, 0, 57, 16};
        thr_tab   = '{16'h0000, 16'($urandom), 16'hFFFF, 16'h7FFF};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // zero threshold straight after reset, recompute with empty rings
        push_cmd(twd_pkg::OP_DETECT, 16'h0000);
        push_cmd(twd_pkg::OP_DETECT, 16'hFFFF);
        push_cmd(twd_pkg::OP_RECOMPUTE, 16'h0000);
        write_start_threshold(16'hFFFF);
        // product wraps past 16 bits for the larger readings
        push_cmd(twd_pkg::OP_DETECT, 16'h0000);
        push_cmd(twd_pkg::OP_DETECT, 16'd6554);
        push_cmd(twd_pkg::OP_DETECT, 16'hFFFF);
        // invalid mark lands in air slot 0, the air ring wraps, then the largest threshold
        push_cmd(twd_pkg::OP_REC_AIR, twd_pkg::INVALID_MARK);
        for (int i = 0; i < SAMPLES - 1; i++)
            push_cmd(twd_pkg::OP_REC_AIR, 16'hFFFE);
        for (int i = 0; i < SAMPLES; i++)
            push_cmd(twd_pkg::OP_REC_WATER, 16'hFFFE);
        push_cmd(twd_pkg::OP_RECOMPUTE, 16'h1234);
        push_cmd(twd_pkg::OP_REC_AIR, 16'hFFFE);
        push_cmd(twd_pkg::OP_RECOMPUTE, 16'h0000);
        push_cmd(twd_pkg::OP_DETECT, 16'd6553);

        for (int p = 0; p < 4; p++)
        begin
            write_start_threshold(thr_tab[p]);
            send_idle_pct  = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            if (p == 0)
                hold_asks++;
            if (p == 2)
            begin
                queue_random(PHASE_ITEMS / 2);
                wait_drained();
                queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            end
            else
                queue_random(PHASE_ITEMS);
        end
        wait_drained();

        $display("tb: %0d items sent, %0d results checked, %0d threshold reloads",
                 cmds_taken, reports_seen, reloads_seen);
        $display("tb: %0d start_threshold writes over four idle/stall mixes", cfg_writes);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
